[hw/rtl/nss_pkg.sv]
package nss_pkg;

  // Width of the request and result fields
  localparam int FIELD_BITS = 25;
  // Room for a product of one more factor of seven above the best size
  localparam int PROD_BITS = FIELD_BITS + 3;
  localparam int VALUE_BITS_DEFAULT = 24;

  // Datapath command codes
  localparam int CMD_BITS = 4;
  localparam logic [CMD_BITS-1:0] CMD_IDLE   = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD   = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_INIT   = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_ENTER5 = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_NEXT7  = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_ENTER3 = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_NEXT5  = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_TRY    = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_KEEP   = 4'd8;
  localparam logic [CMD_BITS-1:0] CMD_FINISH = 4'd9;

  typedef struct packed {
    logic [CMD_BITS-1:0] op;
  } nss_cmd_t;

  typedef struct packed {
    logic p7_below;
    logic p5_below;
    logic p3_below;
  } nss_status_t;

endpackage

[hw/rtl/next_smooth_size_finder.sv]
// Next smooth size finder: returns the smallest 2^a*3^b*5^c*7^d not below a
// requested length, for picking mixed-radix FFT sizes.
//
// Request channel: drive least_value and raise start; the request transfers at
// the rising edge where start is high and busy is low. Requests of zero are
// taken as one; requests above 2^min(VALUE_BITS,24) are clamped to that value.
//
// Result channel: smooth_value is valid for exactly one cycle while done is
// high; the receiver cannot stall it and must take it in that cycle.
//
// Search: the sequencer loops over powers of seven, over powers of five and over odd
// products below the best size so far. Each candidate product is scaled in the
// TRY step and compared against the best size in the KEEP step that follows it.
// busy falls as done rises, so the next request may transfer in the done cycle.
//
// Reset (rst, synchronous, active high) returns the controller to idle and
// drops any search in progress; no result is issued for it.
module next_smooth_size_finder
  import nss_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [FIELD_BITS-1:0] least_value,
  output logic                  busy,
  output logic                  done,
  output logic [FIELD_BITS-1:0] smooth_value
);

  nss_cmd_t    cmd;
  nss_status_t status;

  nss_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  nss_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .least_value  (least_value),
    .cmd          (cmd),
    .status       (status),
    .smooth_value (smooth_value)
  );

endmodule

[hw/rtl/nss_datapath.sv]
module nss_datapath
  import nss_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic [FIELD_BITS-1:0] least_value,
  input  nss_cmd_t              cmd,
  output nss_status_t           status,
  output logic [FIELD_BITS-1:0] smooth_value
);

  // Ceiling: lesser of 2^VALUE_BITS and the largest power of two the field holds
  localparam int CEIL_EXP = (VALUE_BITS < FIELD_BITS - 1) ? VALUE_BITS : FIELD_BITS - 1;
  localparam logic [FIELD_BITS-1:0] CEILING = FIELD_BITS'(1) << CEIL_EXP;
  localparam int WIDE_BITS = 2 * FIELD_BITS;

  logic [FIELD_BITS-1:0] target;
  logic [FIELD_BITS-1:0] best;
  logic [FIELD_BITS-1:0] cand;
  logic [PROD_BITS-1:0]  p7;
  logic [PROD_BITS-1:0]  p5;
  logic [PROD_BITS-1:0]  p3;
  logic [FIELD_BITS-1:0] req_clean;
  logic [FIELD_BITS-1:0] p3_scaled;
  logic [FIELD_BITS-1:0] one_scaled;

  // Scale x by the least power of two that reaches tgt; x is below 2^(FIELD_BITS-1)
  function automatic logic [FIELD_BITS-1:0] scale_up(input logic [FIELD_BITS-2:0] x,
                                                      input logic [FIELD_BITS-1:0] tgt);
    logic [WIDE_BITS-1:0] s;
    logic [FIELD_BITS-1:0] r;
    r = '1;
    for (int k = FIELD_BITS - 1; k >= 0; k--) begin
      s = WIDE_BITS'(x) << k;
      if (s >= WIDE_BITS'(tgt)) begin
        r = s[FIELD_BITS-1:0];
      end
    end
    return r;
  endfunction

  // Clamp the request into one to the ceiling
  always_comb begin
    req_clean = least_value;
    if (least_value == '0) begin
      req_clean = FIELD_BITS'(1);
    end else if (least_value > CEILING) begin
      req_clean = CEILING;
    end
  end

  assign p3_scaled  = scale_up(p3[FIELD_BITS-2:0], target);
  assign one_scaled = scale_up((FIELD_BITS-1)'(1), target);

  assign status.p7_below = p7 < PROD_BITS'(best);
  assign status.p5_below = p5 < PROD_BITS'(best);
  assign status.p3_below = p3 < PROD_BITS'(best);

  // Execute one command per cycle
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_IDLE: begin
      end
      CMD_LOAD: begin
        target <= req_clean;
      end
      CMD_INIT: begin
        best <= one_scaled;
        p7   <= PROD_BITS'(1);
      end
      CMD_ENTER5: begin
        p5 <= p7;
      end
      CMD_NEXT7: begin
        p7 <= p7 * PROD_BITS'(7);
      end
      CMD_ENTER3: begin
        p3 <= p5;
      end
      CMD_NEXT5: begin
        p5 <= p5 * PROD_BITS'(5);
      end
      CMD_TRY: begin
        cand <= p3_scaled;
        p3   <= p3 * PROD_BITS'(3);
      end
      CMD_KEEP: begin
        if (cand < best) begin
          best <= cand;
        end
      end
      CMD_FINISH: begin
        smooth_value <= best;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/nss_ctrl.sv]
module nss_ctrl
  import nss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  nss_status_t status,
  output nss_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_LOOP7 = 3'd2;
  localparam logic [2:0] S_LOOP5 = 3'd3;
  localparam logic [2:0] S_LOOP3 = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       done_next;

  assign busy = state != S_IDLE;

  // Walk powers of seven, then five, then three, trying each product
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd.op     = CMD_IDLE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = CMD_LOAD;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op     = CMD_INIT;
        state_next = S_LOOP7;
      end
      S_LOOP7: begin
        if (status.p7_below) begin
          cmd.op     = CMD_ENTER5;
          state_next = S_LOOP5;
        end else begin
          cmd.op     = CMD_FINISH;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOOP5: begin
        if (status.p5_below) begin
          cmd.op     = CMD_ENTER3;
          state_next = S_LOOP3;
        end else begin
          cmd.op     = CMD_NEXT7;
          state_next = S_LOOP7;
        end
      end
      S_LOOP3: begin
        if (status.p3_below) begin
          cmd.op     = CMD_TRY;
          state_next = S_UPD;
        end else begin
          cmd.op     = CMD_NEXT5;
          state_next = S_LOOP5;
        end
      end
      S_UPD: begin
        cmd.op     = CMD_KEEP;
        state_next = S_LOOP3;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Result strobe only follows the final loop test
  a_done_after_loop7: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_LOOP7 && !$past(status.p7_below))
    else $error("done without finishing the search");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted request did not start the search");

  a_try_then_keep: assert property (@(posedge clk) disable iff (rst)
    cmd.op == CMD_TRY |=> cmd.op == CMD_KEEP)
    else $error("trial candidate not compared");

endmodule
